// ===== rtl/drt_pkg.sv =====
// Shared types and constants of the difficulty retarget core.
package drt_pkg;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_TIMESPAN    = 3'd0;
  localparam logic [2:0] REG_ONE_BLOCK   = 3'd1;
  localparam logic [2:0] REG_NEW_RULE    = 3'd2;
  localparam logic [2:0] REG_NO_RETARGET = 3'd3;
  localparam logic [2:0] REG_LIMIT       = 3'd4;

  localparam logic [31:0] TIMESPAN_RST  = 32'd302400;
  localparam logic [31:0] ONE_BLOCK_RST = 32'd46000;
  localparam logic [31:0] NEW_RULE_RST  = 32'd21000;
  localparam logic [8:0]  LIMIT_RST     = 9'd236;

  localparam int unsigned SPAN_W    = 35;  // clamped span, up to 6T
  localparam int unsigned CARRY_W   = 36;  // word carry of the multiplier row
  localparam int unsigned DIV_STEPS = 8;   // quotient bits per divider cell

  // floor(x/3) = (x * RECIP3) >> 33 for any 32-bit x
  localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

  typedef struct packed {
    logic        bypass;
    logic        shift;
    logic [31:0] bits;
  } drt_side_t;

endpackage

// ===== rtl/drt_front.sv =====
// Front end: compact decode, timespan clamp and pre-shift, two register stages.
module drt_front #(
  parameter int unsigned W = 256
) (
  input  logic                  clk_i,
  input  logic [1:0]            en_i,
  input  logic [31:0]           bits_i,
  input  logic [31:0]           height_i,
  input  logic [31:0]           last_time_i,
  input  logic [31:0]           first_time_i,
  input  logic [31:0]           timespan_i,
  input  logic [31:0]           one_block_i,
  input  logic [31:0]           new_rule_i,
  input  logic                  no_retarget_i,
  input  logic [8:0]            limit_i,
  output logic [W-1:0]          v_o,
  output logic [drt_pkg::SPAN_W-1:0] span_o,
  output drt_pkg::drt_side_t    side_o
);
  import drt_pkg::*;

  localparam logic [8:0] W9 = 9'(W);

  logic [W-1:0]   v1_d, v1_q;
  logic [32:0]    span1_d, span1_q;
  logic           rule1_d, rule1_q;
  drt_side_t      side1_d, side1_q;

  logic [7:0]     size;
  logic [7:0]     diff8;
  logic [10:0]    sa;
  logic [W-1:0]   mz;

  logic [63:0]    prod3;
  logic [30:0]    q3;
  logic [31:0]    r3;
  logic [32:0]    lo;
  logic [34:0]    hi;
  logic signed [35:0] sx;
  logic signed [35:0] sc;
  logic [8:0]     lbw;
  logic           shift;
  drt_side_t      side2;

  // stage 1: decode, raw span and rule test
  always_comb begin
    size = bits_i[31:24];
    mz   = W'(bits_i[22:0]);
    diff8 = (size <= 8'd3) ? (8'd3 - size) : (size - 8'd3);
    sa   = {diff8, 3'b000};
    if (size <= 8'd3) begin
      v1_d = mz >> sa;
    end else begin
      v1_d = mz << sa;
    end
    span1_d = {1'b0, last_time_i} - {1'b0, first_time_i};
    rule1_d = (({1'b0, height_i} + 33'd1) >= {1'b0, one_block_i}) ||
              (height_i >= new_rule_i);
    side1_d.bypass = no_retarget_i;
    side1_d.shift  = 1'b0;
    side1_d.bits   = bits_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      v1_q    <= v1_d;
      span1_q <= span1_d;
      rule1_q <= rule1_d;
      side1_q <= side1_d;
    end
  end

  // stage 2: clamp bounds, clamp, limit test
  always_comb begin
    prod3 = 64'(timespan_i) * 64'(RECIP3);
    q3    = prod3[63:33];
    r3    = timespan_i - {q3, 1'b0} - {1'b0, q3};
    if (rule1_q) begin
      lo = {1'b0, q3, 1'b0} + 33'(r3 == 32'd2);
      hi = {timespan_i, 2'b00} + {1'b0, timespan_i, 1'b0};
    end else begin
      lo = {3'b000, timespan_i[31:2]};
      hi = {1'b0, timespan_i, 2'b00};
    end
    sx = 36'(signed'(span1_q));
    sc = sx;
    if (sc < signed'({3'b000, lo})) begin
      sc = signed'({3'b000, lo});
    end
    if (sc > signed'({1'b0, hi})) begin
      sc = signed'({1'b0, hi});
    end
    lbw   = (limit_i > W9) ? W9 : limit_i;
    shift = (lbw == 9'd0) || ((v1_q >> (lbw - 9'd1)) != '0);
    side2 = side1_q;
    side2.shift = shift;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      v_o    <= shift ? (v1_q >> 1) : v1_q;
      span_o <= sc[SPAN_W-1:0];
      side_o <= side2;
    end
  end

endmodule

// ===== rtl/drt_mul_cell.sv =====
// Multiplier cell: one 32-bit word of the target times the span, carry to the next cell.
module drt_mul_cell #(
  parameter int unsigned PW = 256
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [PW-1:0]               v_i,
  input  logic [PW-1:0]               p_i,
  input  logic [drt_pkg::CARRY_W-1:0] c_i,
  input  logic [drt_pkg::SPAN_W-1:0]  span_i,
  input  drt_pkg::drt_side_t          side_i,
  output logic [PW-1:0]               v_o,
  output logic [PW-1:0]               p_o,
  output logic [drt_pkg::CARRY_W-1:0] c_o,
  output logic [drt_pkg::SPAN_W-1:0]  span_o,
  output drt_pkg::drt_side_t          side_o
);
  import drt_pkg::*;

  logic [31:0] word;
  logic [67:0] t;

  always_comb begin
    word = v_i[31:0];
    t = 68'(64'(word) * 64'(span_i[31:0])) +
        (68'(35'(word) * 35'(span_i[34:32])) << 32) + 68'(c_i);
  end

  // product words enter from the top, so after the last cell they sit in order
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_o    <= v_i >> 32;
      p_o    <= {t[31:0], p_i[PW-1:32]};
      c_o    <= t[67:32];
      span_o <= span_i;
      side_o <= side_i;
    end
  end

endmodule

// ===== rtl/drt_div_cell.sv =====
// Divider cell: eight restoring-division steps on the running remainder.
module drt_div_cell #(
  parameter int unsigned DW = 256
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [31:0]        div_i,
  input  logic [31:0]        r_i,
  input  logic [DW-1:0]      q_i,
  input  drt_pkg::drt_side_t side_i,
  output logic [31:0]        r_o,
  output logic [DW-1:0]      q_o,
  output drt_pkg::drt_side_t side_o
);
  import drt_pkg::*;

  logic [31:0]   r;
  logic [32:0]   rr;
  logic [DW-1:0] q;

  // dividend bits leave the top of q while quotient bits enter at the bottom
  always_comb begin
    r  = r_i;
    q  = q_i;
    rr = '0;
    for (int s = 0; s < DIV_STEPS; s++) begin
      rr = {r, q[DW-1]};
      q  = {q[DW-2:0], 1'b0};
      if (rr >= {1'b0, div_i}) begin
        rr   = rr - {1'b0, div_i};
        q[0] = 1'b1;
      end
      r = rr[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_o    <= r;
      q_o    <= q;
      side_o <= side_i;
    end
  end

endmodule

// ===== rtl/drt_pack.sv =====
// Back end: undo pre-shift, cap at the limit, find the size byte, encode compact form.
module drt_pack #(
  parameter int unsigned W  = 256,
  parameter int unsigned DW = 256
) (
  input  logic               clk_i,
  input  logic [2:0]         en_i,
  input  logic [DW-1:0]      q_i,
  input  drt_pkg::drt_side_t side_i,
  input  logic [31:0]        timespan_i,
  input  logic [8:0]         limit_i,
  output logic [31:0]        next_bits_o
);
  import drt_pkg::*;

  localparam int unsigned AB = (W + 7) / 8;
  localparam int unsigned AW = AB * 8;
  localparam logic [8:0]  W9 = 9'(W);

  logic [W-1:0]  a1_d, a1_q, a2_q, lim, tmp;
  logic [8:0]    lbw;
  logic [AW-1:0] ax;
  logic [7:0]    sz_d, sz2_q, sd;
  logic [10:0]   sa;
  logic [31:0]   c;
  logic [23:0]   c24;
  logic [7:0]    szf;
  drt_side_t     side1_q, side2_q;

  always_comb begin
    lbw = (limit_i > W9) ? W9 : limit_i;
    lim = ~({W{1'b1}} << lbw);
    if (timespan_i == '0) begin
      a1_d = '1;
    end else if (side_i.shift) begin
      a1_d = q_i[W-1:0] << 1;
    end else begin
      a1_d = q_i[W-1:0];
    end
    if ((a1_d & ~lim) != '0) begin
      a1_d = lim;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      a1_q    <= a1_d;
      side1_q <= side_i;
    end
  end

  // size = index of the highest nonzero byte, plus one
  always_comb begin
    ax   = AW'(a1_q);
    sz_d = '0;
    for (int j = 0; j < AB; j++) begin
      if (ax[8*j +: 8] != 8'd0) begin
        sz_d = 8'(j + 1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      a2_q    <= a1_q;
      sz2_q   <= sz_d;
      side2_q <= side1_q;
    end
  end

  always_comb begin
    sd  = (sz2_q <= 8'd3) ? (8'd3 - sz2_q) : (sz2_q - 8'd3);
    sa  = {sd, 3'b000};
    tmp = a2_q >> sa;
    if (sz2_q <= 8'd3) begin
      c = {8'd0, a2_q[23:0]} << sa;
    end else begin
      c = tmp[31:0];
    end
    szf = sz2_q;
    c24 = c[23:0];
    // keep the mantissa positive: move one byte up
    if (c[23]) begin
      c24 = c[31:8];
      szf = sz2_q + 8'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      next_bits_o <= side2_q.bypass ? side2_q.bits : {szf, c24};
    end
  end

endmodule

// ===== rtl/difficulty_retarget_core.sv =====
// Top level of the difficulty retarget core: register file, cell rows, flow control.
//
//  channel   dir  beat fields
//  s_axis    in   last_bits, last_height, last_time, first_time
//  m_axis    out  next_bits
//  apb       in   target_timespan, one_block_height, new_rule_height, no_retarget, limit_bits
//
// One beat per cycle while the row advances; the result passes the front end, the multiplier
// cells, the row of divider cells (eight quotient bits per cell) and the back end.
// Reset clears the valid bits and loads the register defaults; no clearing pass.
// A stalled output holds; the row keeps moving while its last stage is empty.
module difficulty_retarget_core #(
  parameter int unsigned TARGET_WIDTH = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // last_bits, last_height, last_time, first_time
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [31:0]  m_axis_tdata,  // next_bits
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import drt_pkg::*;

  localparam int unsigned W    = TARGET_WIDTH;
  localparam int unsigned NW   = (W + 31) / 32;
  localparam int unsigned PW   = NW * 32;
  localparam int unsigned NDIV = (W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int unsigned DW   = NDIV * DIV_STEPS;
  localparam int unsigned NP   = 4 + NW + NDIV;

  logic [31:0] timespan_q, one_block_q, new_rule_q;
  logic        no_retarget_q;
  logic [8:0]  limit_q;

  logic [NP-1:0] vld_q;
  logic          out_v_q;
  logic          out_ld, adv, s_fire;

  logic [W-1:0]       fv;
  logic [SPAN_W-1:0]  fspan;
  drt_side_t          fside;

  logic [PW-1:0]      mv    [0:NW];
  logic [PW-1:0]      mp    [0:NW];
  logic [CARRY_W-1:0] mc    [0:NW];
  logic [SPAN_W-1:0]  ms    [0:NW];
  drt_side_t          mside [0:NW];

  logic [31:0]        dr    [0:NDIV];
  logic [DW-1:0]      dq    [0:NDIV];
  drt_side_t          dside [0:NDIV];

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timespan_q    <= TIMESPAN_RST;
      one_block_q   <= ONE_BLOCK_RST;
      new_rule_q    <= NEW_RULE_RST;
      no_retarget_q <= 1'b0;
      limit_q       <= LIMIT_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[4:2])
        REG_TIMESPAN:    timespan_q    <= pwdata;
        REG_ONE_BLOCK:   one_block_q   <= pwdata;
        REG_NEW_RULE:    new_rule_q    <= pwdata;
        REG_NO_RETARGET: no_retarget_q <= pwdata[0];
        REG_LIMIT:       limit_q       <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_TIMESPAN:    prdata = timespan_q;
      REG_ONE_BLOCK:   prdata = one_block_q;
      REG_NEW_RULE:    prdata = new_rule_q;
      REG_NO_RETARGET: prdata = {31'd0, no_retarget_q};
      REG_LIMIT:       prdata = {23'd0, limit_q};
      default:         prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // flow control: the row advances unless its last stage is blocked
  assign out_ld        = !out_v_q || m_axis_tready;
  assign adv           = out_ld || !vld_q[NP-1];
  assign s_axis_tready = adv;
  assign s_fire        = s_axis_tvalid && adv;
  assign m_axis_tvalid = out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (adv) begin
        vld_q <= {vld_q[NP-2:0], s_fire};
      end
      if (out_ld) begin
        out_v_q <= vld_q[NP-1];
      end
    end
  end

  drt_front #(.W(W)) u_front (
    .clk_i        (clk_i),
    .en_i         ({adv, adv}),
    .bits_i       (s_axis_tdata[31:0]),
    .height_i     (s_axis_tdata[63:32]),
    .last_time_i  (s_axis_tdata[95:64]),
    .first_time_i (s_axis_tdata[127:96]),
    .timespan_i   (timespan_q),
    .one_block_i  (one_block_q),
    .new_rule_i   (new_rule_q),
    .no_retarget_i(no_retarget_q),
    .limit_i      (limit_q),
    .v_o          (fv),
    .span_o       (fspan),
    .side_o       (fside)
  );

  assign mv[0]    = PW'(fv);
  assign mp[0]    = '0;
  assign mc[0]    = '0;
  assign ms[0]    = fspan;
  assign mside[0] = fside;

  for (genvar k = 0; k < NW; k++) begin : g_mul
    drt_mul_cell #(.PW(PW)) u_cell (
      .clk_i (clk_i),
      .en_i  (adv),
      .v_i   (mv[k]),
      .p_i   (mp[k]),
      .c_i   (mc[k]),
      .span_i(ms[k]),
      .side_i(mside[k]),
      .v_o   (mv[k+1]),
      .p_o   (mp[k+1]),
      .c_o   (mc[k+1]),
      .span_o(ms[k+1]),
      .side_o(mside[k+1])
    );
  end

  // product modulo 2^W becomes the dividend
  assign dr[0]    = '0;
  assign dq[0]    = DW'(mp[NW][W-1:0]);
  assign dside[0] = mside[NW];

  for (genvar k = 0; k < NDIV; k++) begin : g_div
    drt_div_cell #(.DW(DW)) u_cell (
      .clk_i (clk_i),
      .en_i  (adv),
      .div_i (timespan_q),
      .r_i   (dr[k]),
      .q_i   (dq[k]),
      .side_i(dside[k]),
      .r_o   (dr[k+1]),
      .q_o   (dq[k+1]),
      .side_o(dside[k+1])
    );
  end

  drt_pack #(.W(W), .DW(DW)) u_pack (
    .clk_i      (clk_i),
    .en_i       ({out_ld, adv, adv}),
    .q_i        (dq[NDIV]),
    .side_i     (dside[NDIV]),
    .timespan_i (timespan_q),
    .limit_i    (limit_q),
    .next_bits_o(m_axis_tdata)
  );

endmodule

// ===== rtl/drt_checker.sv =====
// Port-level checks of the difficulty retarget core, bound to the top level.
module drt_port_checks (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [31:0]  m_axis_tdata,
  input logic         psel,
  input logic         penable,
  input logic         pwrite,
  input logic [4:0]   paddr,
  input logic [31:0]  pwdata,
  input logic [31:0]  prdata,
  input logic         pready
);
  import drt_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed under stall");

  // an empty output stage never blocks the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");

  // a timespan write reads back on the next cycle
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && (paddr[4:2] == REG_TIMESPAN) |=>
      (paddr[4:2] != REG_TIMESPAN) || (prdata == $past(pwdata)))
    else $error("timespan register readback mismatch");

  // the bypass flag register is one bit wide
  a_flag_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (paddr[4:2] == REG_NO_RETARGET) |-> (prdata[31:1] == 31'd0))
    else $error("bypass register shows stray bits");

endmodule

bind difficulty_retarget_core drt_port_checks u_drt_port_checks (.*);
